@@ design/bqa_pkg.sv @@
// Shared types and constants for the bounded queue admission block.
package bqa_pkg;

  localparam int TIME_W        = 40;
  localparam int ARRIVAL_W     = 32;
  localparam int DURATION_W    = 32;
  localparam int LIMIT_W       = 6;
  localparam int QUEUE_DEPTH_DEF = 64;

  // APB register map
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam logic REG_QUEUE_LIMIT = 1'b0;  // register index, paddr[2]
  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = 6'd63;

  typedef struct packed {
    logic [ARRIVAL_W-1:0]  arrival_time;
    logic [DURATION_W-1:0] duration;
  } job_t;

  typedef struct packed {
    logic              accepted;
    logic [TIME_W-1:0] finish_time;
  } result_t;

endpackage

@@ design/bqa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bqa_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bqa_regs.sv @@
// APB configuration register: queue_limit.
module bqa_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bqa_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bqa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bqa_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [bqa_pkg::LIMIT_W-1:0]      queue_limit
);
  import bqa_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_QUEUE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= QUEUE_LIMIT_RST;
    end else if (wr_en) begin
      queue_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Only one register; unmapped index reads zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_QUEUE_LIMIT) begin
      prdata = APB_DATA_W'(queue_limit);
    end
  end

endmodule

@@ design/bqa_ctrl.sv @@
// Sequencer and shared compare/add datapath over the finish-time FIFO.
module bqa_ctrl #(
  parameter int QUEUE_DEPTH = bqa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bqa_pkg::LIMIT_W-1:0] queue_limit,
  input  logic                        job_valid,
  output logic                        job_stall,
  input  bqa_pkg::job_t               job,
  output logic                        result_valid,
  input  logic                        result_stall,
  output bqa_pkg::result_t            result
);
  import bqa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = OCC_W + LIMIT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WAIT  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state;
  logic [ARRIVAL_W-1:0]  arrival;
  logic [DURATION_W-1:0] dur;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [OCC_W-1:0]      occ;
  logic [TIME_W-1:0]     last_finish;
  result_t               res;

  logic [TIME_W-1:0]     head_fin;
  logic                  pop;
  logic                  admit;
  logic [TIME_W-1:0]     base;
  logic [TIME_W:0]       sum;
  logic [TIME_W-1:0]     fin;
  logic                  push;
  logic                  out_free;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  bqa_ram #(
    .WIDTH(TIME_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .we   (push),
    .waddr(tail),
    .wdata(fin),
    .raddr(head),
    .rdata(head_fin)
  );

  // head entry expired: at or before this arrival
  assign pop   = (occ != '0) && (head_fin <= TIME_W'(arrival));
  assign admit = (CMP_W'(occ) <= CMP_W'(queue_limit)) && (occ != OCC_W'(QUEUE_DEPTH));
  assign base  = (occ == '0) ? TIME_W'(arrival) : last_finish;
  assign sum   = (TIME_W + 1)'(base) + (TIME_W + 1)'(dur);
  assign fin   = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign push  = (state == S_CHECK) && !pop && admit;

  assign job_stall = (state != S_IDLE);
  assign out_free  = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      occ          <= '0;
      last_finish  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (pop) begin
            head  <= wrap_inc(head);
            occ   <= occ - 1'b1;
            state <= S_WAIT;
          end else begin
            if (admit) begin
              tail        <= wrap_inc(tail);
              occ         <= occ + 1'b1;
              last_finish <= fin;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      arrival <= job.arrival_time;
      dur     <= job.duration;
    end
    if (state == S_CHECK && !pop) begin
      res.accepted    <= admit;
      res.finish_time <= admit ? fin : '0;
    end
    if (state == S_DONE && out_free) begin
      result <= res;
    end
  end

endmodule

@@ design/bounded_queue_admission.sv @@
// Top level: bounded queue admission with APB configuration.
// A job is latched in IDLE, then the FIFO head is read (WAIT) and compared
// (CHECK); each expired finish time drained from the head costs one RAM read
// and one compare before the admit decision, then DONE loads the result beat.
// One job at a time: job_stall is high from the accepted job until the result is loaded.
// Reset (rst, synchronous): empty queue, last finish 0, queue_limit 63.
module bounded_queue_admission #(
  parameter int QUEUE_DEPTH = bqa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // job channel
  input  logic                           job_valid,
  output logic                           job_stall,
  input  bqa_pkg::job_t                  job,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output bqa_pkg::result_t               result,
  // APB config
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bqa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bqa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bqa_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bqa_pkg::*;

  logic [LIMIT_W-1:0] queue_limit;

  // queue_limit lives at byte address 0; only paddr[2] is decoded
  bqa_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .queue_limit(queue_limit)
  );

  // Sequencer: latch job, then read/compare head entry, popping expired
  // finish times one at a time, then admit-and-push via the single
  // 41-bit adder with saturation, then hand the beat to the result register.
  bqa_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .queue_limit (queue_limit),
    .job_valid   (job_valid),
    .job_stall   (job_stall),
    .job         (job),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

@@ bench/bqa_admission_checker.sv @@
`timescale 1ns / 1ps
// Checker: tracks the job queue from the ports and checks each result beat.
module bqa_admission_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  input  logic                           job_stall,
  input  bqa_pkg::job_t                  job,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  bqa_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bqa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bqa_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             mismatch_count,
  output int                             results_owed
);
  import bqa_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic [TIME_W-1:0]  finish_shadow [DEPTH];
  int                 head_idx;
  int                 tail_idx;
  int                 in_system;
  logic [TIME_W-1:0]  tail_finish;
  logic [LIMIT_W-1:0] limit_shadow;
  result_t            owed_results [$];

  // drop expired finish times, then admit or reject the job
  function automatic result_t admit_job(job_t j);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] base;
    result_t           r;
    while (in_system != 0 && finish_shadow[head_idx] <= j.arrival_time) begin
      head_idx  = (head_idx + 1) % DEPTH;
      in_system = in_system - 1;
    end
    r = '0;
    if (in_system <= limit_shadow && in_system < DEPTH) begin
      base = (in_system == 0) ? TIME_W'(j.arrival_time) : tail_finish;
      sum  = {1'b0, base} + (TIME_W + 1)'(j.duration);
      // saturate at the top of the time range
      r.finish_time = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
      r.accepted    = 1'b1;
      finish_shadow[tail_idx] = r.finish_time;
      tail_idx    = (tail_idx + 1) % DEPTH;
      in_system   = in_system + 1;
      tail_finish = r.finish_time;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      head_idx       = 0;
      tail_idx       = 0;
      in_system      = 0;
      tail_finish    = '0;
      limit_shadow   = QUEUE_LIMIT_RST;
      mismatch_count = 0;
      owed_results.delete();
    end else begin
      // only index 0 is mapped; other addresses are ignored
      if (psel && penable && pwrite && pready && paddr[2] == REG_QUEUE_LIMIT)
        limit_shadow = pwdata[LIMIT_W-1:0];
      if (result_valid && !result_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result beat, actual accepted=%0b finish=%h",
                   $time, result.accepted, result.finish_time);
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          if (result.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch, expected %0b actual %0b",
                     $time, want.accepted, result.accepted);
            mismatch_count++;
          end
          if (result.finish_time !== want.finish_time) begin
            $display("%0t: finish_time mismatch, expected %h actual %h",
                     $time, want.finish_time, result.finish_time);
            mismatch_count++;
          end
        end
      end
      if (job_valid && !job_stall)
        owed_results.push_back(admit_job(job));
    end
    results_owed = owed_results.size();
  end

endmodule

@@ bench/bounded_queue_admission_tb.sv @@
`timescale 1ns / 1ps
// Top of the bench: clock, reset, job and register stimulus, stall pattern, watchdog and verdict.
module bounded_queue_admission_tb;
  import bqa_pkg::*;

  localparam int IDLE_LIMIT    = 4000;  // cycles with no beat before we give up
  localparam int LONG_HOLD     = 400;   // receiver back-pressure stretch
  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 100;
  localparam int TAIL_ITEMS    = 42;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR    = {REG_QUEUE_LIMIT, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'b100;

  // arrival/duration mixes; heavy fills the queue, bursty fills then drains
  typedef enum int {LOAD_LIGHT, LOAD_HEAVY, LOAD_BURSTY} load_e;

  logic                  clk;
  logic                  rst;
  logic                  job_valid;
  logic                  job_stall;
  job_t                  job;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          mismatch_count;
  int          results_owed;
  int          quiet_cycles;
  logic [31:0] arrival_now;   // running arrival clock for well-formed sequences
  bit          send_steady;   // sender offers back to back
  bit          recv_steady;   // receiver never stalls
  bit          hold_long;     // request one long receiver hold

  // queue_limit per phase; -1 picks a random value
  int limit_plan [PHASES] = '{63, 0, 1, 62, -1, 63, 7, -1, 0, 63, 2, -1, 31};

  bounded_queue_admission dut (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_stall    (job_stall),
    .job          (job),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  bqa_admission_checker admission_check (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job_stall      (job_stall),
    .job            (job),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if ((job_valid && !job_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall before each beat, none in steady phases,
  // and one long hold when the stimulus asks for it.
  initial begin
    int n;
    result_stall = 1'b0;
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = recv_steady ? 0 : $urandom_range(0, 13);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  function automatic job_t job_of(logic [31:0] arrival, logic [31:0] duration);
    job_t j;
    j.arrival_time = arrival;
    j.duration     = duration;
    return j;
  endfunction

  // Mostly nondecreasing arrivals; a few step backwards, a few have zero duration.
  function automatic job_t next_job(load_e load);
    int unsigned roll;
    int unsigned inc;
    job_t        j;
    roll = $urandom_range(0, 99);
    case (load)
      LOAD_LIGHT: inc = $urandom_range(0, 400);
      LOAD_HEAVY: inc = $urandom_range(0, 15);
      default:    inc = ($urandom_range(0, 9) == 0) ? $urandom_range(2000, 20000)
                                                     : $urandom_range(0, 5);
    endcase
    if (roll < 4) begin
      if (arrival_now < 1000) j.arrival_time = 0;
      else j.arrival_time = arrival_now - $urandom_range(1, 1000);
    end else begin
      arrival_now    = arrival_now + inc;
      j.arrival_time = arrival_now;
    end
    if (roll >= 97) j.duration = 0;
    else j.duration = $urandom_range(1, (load == LOAD_LIGHT) ? 150 : 300);
    return j;
  endfunction

  // Drop valid and wait until every outstanding result beat has been taken.
  task automatic quiesce();
    job_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    quiesce();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One job beat; valid stays up so a following beat can go back to back.
  task automatic send_job(job_t j);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      job_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    job_valid <= 1'b1;
    job       <= j;
    do @(posedge clk); while (!(job_valid && !job_stall));
  endtask

  initial begin
    int    lim;
    load_e load;
    rst          = 1'b1;
    job_valid    = 1'b0;
    job          = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    quiet_cycles = 0;
    arrival_now  = 0;
    send_steady  = 1'b0;
    recv_steady  = 1'b0;
    hold_long    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero duration on an empty queue, drain at equal time,
    // chaining on the tail, full drain, arrival going backwards.
    send_job(job_of(0, 0));
    send_job(job_of(0, 1));
    send_job(job_of(0, 5));
    send_job(job_of(1, 1));
    send_job(job_of(10, 3));
    send_job(job_of(5, 2));
    // limit 0: only a job finding the queue empty gets in
    write_reg(LIMIT_ADDR, 0);
    send_job(job_of(20, 10));
    send_job(job_of(20, 10));
    send_job(job_of(30, 4));
    // a write outside the map must leave the limit at 0
    write_reg(UNMAPPED_ADDR, 63);
    send_job(job_of(31, 1));
    arrival_now = 40;

    // Random phases, each with its own limit, load mix and idle pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      lim = (limit_plan[ph] < 0) ? $urandom_range(0, 63) : limit_plan[ph];
      write_reg(LIMIT_ADDR, lim);
      load        = load_e'($urandom_range(0, 2));
      send_steady = (ph % 3 == 1);
      recv_steady = (ph % 4 == 2);
      if (ph == 4) begin
        // long receiver hold while the sender keeps offering: block backs up
        hold_long   = 1'b1;
        send_steady = 1'b1;
        load        = LOAD_HEAVY;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // sender pause mid-phase until everything has come back
        if (ph == 8 && k == PHASE_ITEMS / 2) quiesce();
        send_job(next_job(load));
      end
    end

    // Extremes last: large finish times never drain afterwards.
    write_reg(LIMIT_ADDR, 63);
    send_steady = 1'b0;
    recv_steady = 1'b0;
    send_job(job_of(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_job(job_of(0, 32'hFFFF_FFFF));
    send_job(job_of(32'hFFFF_FFFF, 1));
    for (int k = 0; k < TAIL_ITEMS; k++)
      send_job(job_of($urandom, $urandom));

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/bqa_pkg.sv
design/bqa_ram.sv
design/bqa_regs.sv
design/bqa_ctrl.sv
design/bounded_queue_admission.sv
bench/bqa_admission_checker.sv
bench/bounded_queue_admission_tb.sv
